@@ hw/rtl/iss_pkg.sv @@
// Shared types and constants for the insertion sort core.
// No dependencies; used by every other file of the block but iss_in_if.
package iss_pkg;

    localparam int MAX_ITEMS_DEF  = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CNT_W          = 12;

    // Each insertion after the first costs one compare and two moves, plus one of each per shift
    localparam logic [CNT_W-1:0] CMP_BASE = CNT_W'(1);
    localparam logic [CNT_W-1:0] MOV_BASE = CNT_W'(2);

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctrl;

endpackage

@@ hw/rtl/iss_in_if.sv @@
// Input channel of the insertion sort core: valid/ready plus one value and an end-of-set flag.
// Depends on nothing but the DATA_WIDTH parameter.
interface iss_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] value;
    logic                  end_of_set;

    modport source (output valid, output value, output end_of_set, input ready);
    modport sink   (input valid, input value, input end_of_set, output ready);
endinterface

@@ hw/rtl/iss_out_if.sv @@
// Output channel of the insertion sort core: sorted values with set totals.
// Depends on iss_pkg for the counter width.
interface iss_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                     valid;
    logic                     ready;
    logic [DATA_WIDTH-1:0]    sorted_value;
    logic                     last_of_run;
    logic [iss_pkg::CNT_W-1:0] compare_total;
    logic [iss_pkg::CNT_W-1:0] move_total;
    logic                     overflowed;

    modport source (output valid, output sorted_value, output last_of_run,
                    output compare_total, output move_total, output overflowed,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_of_run,
                    input compare_total, input move_total, input overflowed,
                    output ready);
endinterface

@@ hw/rtl/iss_cell.sv @@
// One slot of the systolic insertion chain: holds one sorted value.
// Depends on iss_pkg for the control struct.
module iss_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  iss_pkg::t_cell_ctrl   i_ctrl,
    input  logic [DATA_WIDTH-1:0] i_new,
    input  logic                  i_occ,
    input  logic                  i_left_occ,
    input  logic                  i_left_take,
    input  logic [DATA_WIDTH-1:0] i_left_val,
    input  logic [DATA_WIDTH-1:0] i_right_val,
    output logic                  o_take,
    output logic [DATA_WIDTH-1:0] o_val
);
    import iss_pkg::*;

    logic [DATA_WIDTH-1:0] r_val;
    logic [DATA_WIDTH-1:0] n_val;
    logic                  gt;

    // Strictly greater keeps equal values in arrival order
    assign gt     = i_occ && ($signed(i_new) < $signed(r_val));
    // Take a value when shifted up, or when this is the first free slot
    assign o_take = gt || (!i_occ && i_left_occ);
    assign o_val  = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.insert && o_take) begin
            n_val = i_left_take ? i_left_val : i_new;
        end else if (i_ctrl.shift) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

@@ hw/rtl/insertion_sort_with_counts_core.sv @@
// Insertion sort core: a chain of cells takes one value per cycle, in order.
// After the end-of-set transfer the first result is valid in the next cycle.
// One insertion per cycle while filling, then one result per cycle while the sink
// is ready, for the n stored values; no input is taken while the set drains.
// Reset (synchronous, active low) clears the state, count, totals and overflow flag;
// cell contents are not reset. Depends on iss_pkg, iss_in_if, iss_out_if, iss_cell.
module insertion_sort_with_counts_core #(
    parameter int MAX_ITEMS  = iss_pkg::MAX_ITEMS_DEF,
    parameter int DATA_WIDTH = iss_pkg::DATA_WIDTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    iss_in_if.sink   i_in_ch,
    iss_out_if.source o_out_ch
);
    import iss_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CNT_W-1:0] r_cmp, n_cmp;
    logic [CNT_W-1:0] r_mov, n_mov;
    logic             r_ovf, n_ovf;

    t_cell_ctrl            ctrl;
    logic                  in_xfer, out_xfer, room;
    logic [CW-1:0]         pos;
    logic [CNT_W-1:0]      shifts;
    logic                  take [MAX_ITEMS];
    logic [DATA_WIDTH-1:0] cval [MAX_ITEMS];

    assign in_xfer  = i_in_ch.valid && i_in_ch.ready;
    assign out_xfer = o_out_ch.valid && o_out_ch.ready;
    assign room     = r_count < CW'(MAX_ITEMS);

    assign ctrl.insert = in_xfer && room;
    assign ctrl.shift  = out_xfer;

    genvar g;
    generate
        for (g = 0; g < MAX_ITEMS; g++) begin : g_cell
            logic                  left_occ, left_take;
            logic [DATA_WIDTH-1:0] left_val, right_val;
            if (g == 0) begin : g_head
                assign left_occ  = 1'b1;
                assign left_take = 1'b0;
                assign left_val  = '0;
            end else begin : g_mid
                assign left_occ  = CW'(g - 1) < r_count;
                assign left_take = take[g-1];
                assign left_val  = cval[g-1];
            end
            if (g == MAX_ITEMS - 1) begin : g_tail
                assign right_val = '0;
            end else begin : g_body
                assign right_val = cval[g+1];
            end
            iss_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (ctrl),
                .i_new       (i_in_ch.value),
                .i_occ       (CW'(g) < r_count),
                .i_left_occ  (left_occ),
                .i_left_take (left_take),
                .i_left_val  (left_val),
                .i_right_val (right_val),
                .o_take      (take[g]),
                .o_val       (cval[g])
            );
        end
    endgenerate

    // Encode the slot where the new value lands: the first cell that takes
    always_comb begin
        pos = '0;
        for (int i = 0; i < MAX_ITEMS; i++) begin
            if (take[i] && (i == 0 || !take[(i == 0) ? 0 : i-1])) begin
                pos = pos | CW'(i);
            end
        end
    end

    assign shifts = CNT_W'(r_count - pos);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_cmp   = r_cmp;
        n_mov   = r_mov;
        n_ovf   = r_ovf;
        if (in_xfer) begin
            if (room) begin
                n_count = r_count + CW'(1);
                if (r_count != '0) begin
                    n_cmp = r_cmp + CMP_BASE + shifts;
                    n_mov = r_mov + MOV_BASE + shifts;
                end
            end else begin
                n_ovf = 1'b1;
            end
            if (i_in_ch.end_of_set) begin
                n_state = ST_DRAIN;
            end
        end
        if (out_xfer) begin
            if (o_out_ch.last_of_run) begin
                // Run done: clear for the next set
                n_state = ST_FILL;
                n_count = '0;
                n_cmp   = '0;
                n_mov   = '0;
                n_ovf   = 1'b0;
            end else begin
                n_count = r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_count <= '0;
            r_cmp   <= '0;
            r_mov   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cmp   <= n_cmp;
            r_mov   <= n_mov;
            r_ovf   <= n_ovf;
        end
    end

    assign i_in_ch.ready          = (r_state == ST_FILL);
    assign o_out_ch.valid         = (r_state == ST_DRAIN);
    assign o_out_ch.sorted_value  = cval[0];
    assign o_out_ch.last_of_run   = (r_count == CW'(1));
    assign o_out_ch.compare_total = r_cmp;
    assign o_out_ch.move_total    = r_mov;
    assign o_out_ch.overflowed    = r_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("element count beyond capacity");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ch.ready && o_out_ch.valid))
        else $error("input and output active together");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && room) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insertion did not grow the store");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_out_ch.last_of_run) |=>
            (r_count == '0 && r_cmp == '0 && r_mov == '0 && !r_ovf))
        else $error("state not cleared after run");

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ch.valid |-> (r_count != '0))
        else $error("drain with empty store");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for insertion_sort_with_counts_core: streams signed sets in,
// predicts sorted runs and totals, and compares every transfer on the output channel.
// Depends on iss_pkg, iss_in_if, iss_out_if and the core itself.
module tb;

    import iss_pkg::*;

    localparam int DW       = DATA_WIDTH_DEF;
    localparam int CAPACITY = MAX_ITEMS_DEF;
    localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};

    typedef struct packed {
        logic signed [DW-1:0] value;
        logic                 last;
        logic [CNT_W-1:0]     cmp_total;
        logic [CNT_W-1:0]     mov_total;
        logic                 dropped;
    } t_sorted_entry;

    logic i_clk = 1'b0;
    logic i_rst_n;

    iss_in_if  #(.DATA_WIDTH(DW)) in_ch ();
    iss_out_if #(.DATA_WIDTH(DW)) out_ch ();

    insertion_sort_with_counts_core #(
        .MAX_ITEMS  (CAPACITY),
        .DATA_WIDTH (DW)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the sorted store and the per-set totals
    logic signed [DW-1:0] shadow_store [CAPACITY];
    int                   shadow_fill;
    logic [CNT_W-1:0]     shadow_cmp;
    logic [CNT_W-1:0]     shadow_mov;
    logic                 shadow_drop;

    t_sorted_entry expected_sorted_q [$];

    int  fail_count;
    int  items_sent;
    int  sets_closed;
    int  dropped_total;
    int  results_checked;
    bit  src_gaps;
    bit  sink_stalls;

    function automatic void predict_transfer(input logic signed [DW-1:0] v, input logic eos);
        int            pos;
        int            k;
        t_sorted_entry e;
        if (shadow_fill == CAPACITY) begin
            shadow_drop = 1'b1;
            dropped_total++;
        end else begin
            pos = shadow_fill;
            if (pos > 0) begin
                shadow_cmp = shadow_cmp + CMP_BASE;
                shadow_mov = shadow_mov + MOV_BASE;
            end
            // Shift strictly greater entries up; equal values stay ahead
            while (pos > 0 && v < shadow_store[pos-1]) begin
                shadow_store[pos] = shadow_store[pos-1];
                shadow_cmp = shadow_cmp + 1'b1;
                shadow_mov = shadow_mov + 1'b1;
                pos--;
            end
            shadow_store[pos] = v;
            shadow_fill++;
        end
        if (eos) begin
            for (k = 0; k < shadow_fill; k++) begin
                e.value     = shadow_store[k];
                e.last      = (k == shadow_fill - 1);
                e.cmp_total = shadow_cmp;
                e.mov_total = shadow_mov;
                e.dropped   = shadow_drop;
                expected_sorted_q.push_back(e);
            end
            sets_closed++;
            shadow_fill = 0;
            shadow_cmp  = '0;
            shadow_mov  = '0;
            shadow_drop = 1'b0;
        end
    endfunction

    // Check results first, then record the input transfer of the same edge
    always @(posedge i_clk) begin
        t_sorted_entry e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_sorted_q.size() == 0) begin
                $error("unexpected result: sorted_value %0d", $signed(out_ch.sorted_value));
                fail_count++;
            end else begin
                e = expected_sorted_q.pop_front();
                results_checked++;
                if (out_ch.sorted_value !== e.value) begin
                    $error("sorted_value: expected %0d, got %0d", e.value,
                           $signed(out_ch.sorted_value));
                    fail_count++;
                end
                if (out_ch.last_of_run !== e.last) begin
                    $error("last_of_run: expected %0d, got %0d", e.last, out_ch.last_of_run);
                    fail_count++;
                end
                if (out_ch.compare_total !== e.cmp_total) begin
                    $error("compare_total: expected %0d, got %0d", e.cmp_total,
                           out_ch.compare_total);
                    fail_count++;
                end
                if (out_ch.move_total !== e.mov_total) begin
                    $error("move_total: expected %0d, got %0d", e.mov_total,
                           out_ch.move_total);
                    fail_count++;
                end
                if (out_ch.overflowed !== e.dropped) begin
                    $error("overflowed: expected %0d, got %0d", e.dropped, out_ch.overflowed);
                    fail_count++;
                end
            end
        end
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            predict_transfer(in_ch.value, in_ch.end_of_set);
        end
    end

    initial out_ch.ready = 1'b0;

    always @(negedge i_clk) begin
        out_ch.ready <= sink_stalls ? ($urandom_range(99) >= 24) : 1'b1;
    end

    function automatic logic signed [DW-1:0] rand_value();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return DW'($urandom());
            5, 6, 7:       return DW'(int'($urandom_range(8)) - 4);
            default: begin
                case ($urandom_range(3))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    // with valid still high, so a following item can reuse the cycle.
    task automatic send_value(input logic signed [DW-1:0] v, input logic eos);
        while (src_gaps && $urandom_range(99) < 24) begin
            in_ch.valid      <= 1'b0;
            in_ch.value      <= DW'($urandom());
            in_ch.end_of_set <= 1'($urandom());
            @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.value      <= v;
        in_ch.end_of_set <= eos;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        items_sent++;
        @(negedge i_clk);
    endtask

    // Hold off the sender until every predicted result has been taken
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_sorted_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic send_set(input logic signed [DW-1:0] vals [$]);
        int k;
        for (k = 0; k < vals.size(); k++) send_value(vals[k], k == vals.size() - 1);
    endtask

    task automatic test_directed();
        send_set('{VAL_MIN});
        send_set('{VAL_MAX});
        send_set('{VAL_MAX, VAL_MIN, 0, -1, 1, VAL_MIN, VAL_MAX});
        send_set('{7, 6, 5, 4, 3, 2, 1, 0});
        send_set('{-2, -1, 0, 1, 2});
        wait_drained();
    endtask

    task automatic test_capacity();
        int k;
        // Strictly descending full store drives both totals to their maximum
        for (k = 0; k < CAPACITY; k++) send_value(DW'(1000 - 3 * k), k == CAPACITY - 1);
        wait_drained();
        // Two values past capacity are dropped; the second of them closes the set
        for (k = 0; k < CAPACITY + 2; k++) send_value(rand_value(), k == CAPACITY + 1);
        wait_drained();
    endtask

    task automatic test_back_to_back(input int target);
        int first;
        int n;
        int k;
        first       = items_sent;
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        while (items_sent - first < target) begin
            n = $urandom_range(8, 1);
            for (k = 0; k < n; k++) send_value(rand_value(), k == n - 1);
        end
        wait_drained();
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
    endtask

    task automatic test_random_sets(input int target);
        int first;
        int n;
        int k;
        int pick;
        first = items_sent;
        while (items_sent - first < target) begin
            pick = $urandom_range(99);
            if (pick < 70)      n = $urandom_range(12, 1);
            else if (pick < 90) n = $urandom_range(40, 13);
            else                n = $urandom_range(70, 55);
            for (k = 0; k < n; k++) send_value(rand_value(), k == n - 1);
            if ($urandom_range(7) == 0) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        fail_count       = 0;
        items_sent       = 0;
        sets_closed      = 0;
        dropped_total    = 0;
        results_checked  = 0;
        shadow_fill      = 0;
        shadow_cmp       = '0;
        shadow_mov       = '0;
        shadow_drop      = 1'b0;
        src_gaps         = 1'b1;
        sink_stalls      = 1'b1;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.value      = '0;
        in_ch.end_of_set = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_capacity();
        test_back_to_back(40);
        test_random_sets(100);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d values in %0d sets, %0d dropped at capacity.",
                 items_sent, sets_closed, dropped_total);
        $display("Checked %0d sorted results against predicted order and totals.",
                 results_checked);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout: %0d results still outstanding", expected_sorted_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
